// ----- hw/rtl/mscg_pkg.sv -----
package mscg_pkg;

    localparam int unsigned PROG_W      = 16;  // progress and stop position width
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned COLOR_W     = 32;  // red[31:24] green[23:16] blue[15:8] alpha[7:0]
    localparam int unsigned STOP_W      = 48;
    localparam int unsigned NUM_CHAN    = 4;
    localparam int unsigned NUM_W       = PROG_W + CHAN_W;  // interpolation numerator
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int unsigned DEF_MAX_STOPS = 7;
    localparam int unsigned DEF_POS_BITS  = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST = 3'd1;

    // Reset contents
    localparam logic [2:0]        RST_STOP_COUNT = 3'd2;
    localparam logic [STOP_W-1:0] RST_STOP_0     = 48'h0000_0000_00FF;
    localparam logic [STOP_W-1:0] RST_STOP_N     = 48'hFFFF_FFFF_FFFF;

    // One queued interpolation job: result = (lo*(w-d) + hi*d) / w per channel
    typedef struct packed {
        logic [COLOR_W-1:0] c_lo;
        logic [COLOR_W-1:0] c_hi;
        logic [PROG_W-1:0]  w;
        logic [PROG_W-1:0]  d;
    } t_item;

endpackage

// ----- hw/rtl/mscg_front.sv -----
module mscg_front #(
    parameter int unsigned MAX_STOPS = mscg_pkg::DEF_MAX_STOPS,
    parameter int unsigned POS_BITS  = mscg_pkg::DEF_POS_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mscg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mscg_pkg::STOP_W-1:0]    i_cfg_data,
    input  logic                           i_valid,
    input  logic [mscg_pkg::PROG_W-1:0]    i_progress,
    output logic                           o_ready,
    output logic                           o_push,
    output mscg_pkg::t_item                o_item,
    input  logic                           i_full
);
    import mscg_pkg::*;

    localparam int unsigned IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam logic [2:0] MAXN = 3'(MAX_STOPS);
    localparam logic [PROG_W-1:0] POS_MASK = (POS_BITS >= PROG_W) ? {PROG_W{1'b1}} :
                                             PROG_W'((32'd1 << POS_BITS) - 32'd1);

    logic [2:0]        r_sc;
    logic [STOP_W-1:0] r_stop [MAX_STOPS];
    logic              r_fv;
    logic [PROG_W-1:0] r_fp;

    logic [2:0]        n_used;
    logic [PROG_W-1:0] pos [MAX_STOPS];
    logic [PROG_W-1:0] p;
    logic [IW-1:0]     k;
    logic              found;
    logic [IW-1:0]     last_idx;
    logic              accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc <= RST_STOP_COUNT;
            for (int i = 0; i < MAX_STOPS; i++) begin
                r_stop[i] <= (i == 0) ? RST_STOP_0 : RST_STOP_N;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_STOP_COUNT) begin
                r_sc <= i_cfg_data[2:0];
            end
            for (int i = 0; i < MAX_STOPS; i++) begin
                if (i_cfg_idx == CFG_IDX_W'(i) + REG_STOP_FIRST) begin
                    r_stop[i] <= i_cfg_data;
                end
            end
        end
    end

    assign o_push  = r_fv && !i_full;
    assign o_ready = !r_fv || !i_full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (accept) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fp <= i_progress;
        end
    end

    // Classify: find the first used stop at or beyond progress
    always_comb begin
        n_used = (r_sc < 3'd2) ? 3'd2 : ((r_sc > MAXN) ? MAXN : r_sc);
        p      = r_fp & POS_MASK;
        for (int i = 0; i < MAX_STOPS; i++) begin
            pos[i] = r_stop[i][STOP_W-1:COLOR_W] & POS_MASK;
        end
        k     = '0;
        found = 1'b0;
        for (int i = MAX_STOPS - 1; i >= 0; i--) begin
            if ((3'(i) < n_used) && (pos[i] >= p)) begin
                k     = IW'(i);
                found = 1'b1;
            end
        end
        last_idx = IW'(n_used - 3'd1);
    end

    always_comb begin
        o_item = '0;
        if (!found) begin
            o_item.c_lo = r_stop[last_idx][COLOR_W-1:0];
            o_item.w    = PROG_W'(1);
        end else if (k == '0) begin
            o_item.c_lo = r_stop[0][COLOR_W-1:0];
            o_item.w    = PROG_W'(1);
        end else begin
            o_item.c_lo = r_stop[k - IW'(1)][COLOR_W-1:0];
            o_item.c_hi = r_stop[k][COLOR_W-1:0];
            o_item.w    = pos[k] - pos[k - IW'(1)];
            o_item.d    = p - pos[k - IW'(1)];
        end
    end

    a_push_nonzero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_item.w != '0) && (o_item.d <= o_item.w))
        else $error("front produced a bad span");
endmodule

// ----- hw/rtl/mscg_queue.sv -----
module mscg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mscg_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output mscg_pkg::t_item o_item
);
    import mscg_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue underflow");
endmodule

// ----- hw/rtl/mscg_back.sv -----
module mscg_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  mscg_pkg::t_item                  i_item,
    output logic                             o_pop,
    output logic                             o_valid,
    output logic [mscg_pkg::COLOR_W-1:0]     o_color,  // red[31:24] .. alpha[7:0]
    input  logic                             i_ready
);
    import mscg_pkg::*;

    localparam int unsigned NSTG = CHAN_W + 1;  // multiply stage + one stage per quotient bit

    logic              r_v   [NSTG];
    logic [PROG_W-1:0] r_w   [NSTG];
    logic [NUM_W-1:0]  r_rem [NSTG][NUM_CHAN];
    logic [CHAN_W-1:0] r_q   [NSTG][NUM_CHAN];

    logic en;

    // Whole pipe advances together; hold while the last stage waits
    assign en      = !r_v[NSTG-1] || i_ready;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) r_v[s] <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_empty;
            for (int s = 1; s < NSTG; s++) r_v[s] <= r_v[s-1];
        end
    end

    // Stage 0: weighted sum lo*(w-d) + hi*d per channel
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w[0] <= i_item.w;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_rem[0][c] <= NUM_W'(
                    ({(NUM_W+1)'(0)} | ((NUM_W+1)'(i_item.c_lo[COLOR_W-1-CHAN_W*c -: CHAN_W])
                                        * (NUM_W+1)'(i_item.w - i_item.d)))
                    + ((NUM_W+1)'(i_item.c_hi[COLOR_W-1-CHAN_W*c -: CHAN_W])
                       * (NUM_W+1)'(i_item.d)));
                r_q[0][c] <= '0;
            end
        end
    end

    // Restoring divide, one quotient bit per stage, most significant first
    for (genvar s = 1; s < NSTG; s++) begin : g_div
        localparam int unsigned B = NSTG - 1 - s;
        for (genvar c = 0; c < NUM_CHAN; c++) begin : g_ch
            logic [NUM_W-1:0] dv;
            logic             ge;
            assign dv = NUM_W'(r_w[s-1]) << B;
            assign ge = r_rem[s-1][c] >= dv;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[s][c]  <= ge ? (r_rem[s-1][c] - dv) : r_rem[s-1][c];
                    r_q[s][c]    <= r_q[s-1][c] | (ge ? CHAN_W'(1) << B : '0);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) r_w[s] <= r_w[s-1];
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            o_color[COLOR_W-1-CHAN_W*c -: CHAN_W] = r_q[NSTG-1][c];
        end
    end

    a_rem_below_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-1] |-> (r_rem[NSTG-1][0] < NUM_W'(r_w[NSTG-1])) &&
                        (r_rem[NSTG-1][3] < NUM_W'(r_w[NSTG-1])))
        else $error("divide remainder not below divisor");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG-1] && !i_ready) |=> r_v[NSTG-1] && $stable(o_color))
        else $error("result changed while stalled");
endmodule

// ----- hw/rtl/multi_stop_color_gradient.sv -----
// Multi-stop linear RGBA8 gradient, one progress value per beat in, one color per beat out.
// Path from input beat to output valid: queue write, weighted-sum multiply stage, eight
// divide stages; the input register loads with the beat. Throughput: one beat per cycle
// without output stall; the divider is fully pipelined, one quotient bit a stage.
// Reset (synchronous, active low): empties the pipe and queue, stop_count = 2,
// stop 0 = opaque black at 0, stops 1..6 = opaque white at full scale.
module multi_stop_color_gradient #(
    parameter int unsigned MAX_STOPS = mscg_pkg::DEF_MAX_STOPS,
    parameter int unsigned POS_BITS  = mscg_pkg::DEF_POS_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port: index 0 stop_count, 1..7 stop_0..stop_6
    input  logic                           i_cfg_we,
    input  logic [mscg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mscg_pkg::STOP_W-1:0]    i_cfg_data,
    // progress stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // [15:0] progress
    // color stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata   // red, green, blue, alpha from bit 0
);
    import mscg_pkg::*;

    t_item              push_item;
    t_item              head_item;
    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    logic [COLOR_W-1:0] color;

    // Front: hold configuration, pick the stop pair for each beat
    mscg_front #(
        .MAX_STOPS (MAX_STOPS),
        .POS_BITS  (POS_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_progress (s_axis_tdata),
        .o_ready    (s_axis_tready),
        .o_push     (push),
        .o_item     (push_item),
        .i_full     (full)
    );

    // Short queue decouples classification from the arithmetic pipe
    mscg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (head_item)
    );

    // Back: multiply then divide, stall as a whole on output backpressure
    mscg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_color (color),
        .i_ready (m_axis_tready)
    );

    // Repack: red lowest on the bus
    assign m_axis_tdata = {color[7:0], color[15:8], color[23:16], color[31:24]};
endmodule
